/* hw/rtl/dr_pkg.sv */
// Shared types and constants for the difficulty retarget block.
// No dependencies.
`default_nettype none
package dr_pkg;

    localparam int TGT_W   = 256;
    localparam int REM_W   = 32;
    localparam int CELLS   = 32;
    localparam int CELL_BITS = TGT_W / CELLS;

    localparam logic [2:0] CFG_POW_LIMIT0 = 3'd0;
    localparam logic [2:0] CFG_POW_LIMIT1 = 3'd1;
    localparam logic [2:0] CFG_POW_LIMIT2 = 3'd2;
    localparam logic [2:0] CFG_POW_LIMIT3 = 3'd3;
    localparam logic [2:0] CFG_NO_RETGT   = 3'd4;
    localparam logic [2:0] CFG_TIMESPAN   = 3'd5;

    // One word in flight through the divider row.
    typedef struct packed {
        logic              valid;
        logic              pass;
        logic [31:0]       bits;
        logic [REM_W-1:0]  rem;
        logic [TGT_W-1:0]  word;
    } t_cell_word;

endpackage
`default_nettype wire

/* hw/rtl/difficulty_retarget.sv */
// Top level of the difficulty retarget block: front end, divider row, clamp and encode.
// Depends on dr_pkg and dr_cell.
`default_nettype none
// The block takes one word per cycle while the output is not stalled and gives one new
// compact target per word. Each word passes through the registered stages in order: the
// timespan clamp and mantissa multiply, the row of divider cells (each retires eight
// quotient bits of the 256-bit scaled target), the pow-limit clamp and the compact
// encode into the output register. The whole pipeline holds when the output word is
// stalled. Configuration must be written only while the pipeline is empty.
module difficulty_retarget (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire [31:0] i_last_bits,
    input  wire [31:0] i_last_block_time,
    input  wire [31:0] i_first_block_time,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [31:0] o_new_bits,
    input  wire        i_cfg_we,
    input  wire [2:0]  i_cfg_index,
    input  wire [63:0] i_cfg_data
);

    // ---- configuration registers
    logic [255:0] r_limit;
    logic         r_no_retgt;
    logic [31:0]  r_tt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= {64'h0000_0000_FFFF_FFFF, {192{1'b1}}};
            r_no_retgt <= 1'b0;
            r_tt       <= 32'd1209600;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dr_pkg::CFG_POW_LIMIT0: r_limit[63:0]    <= i_cfg_data;
                dr_pkg::CFG_POW_LIMIT1: r_limit[127:64]  <= i_cfg_data;
                dr_pkg::CFG_POW_LIMIT2: r_limit[191:128] <= i_cfg_data;
                dr_pkg::CFG_POW_LIMIT3: r_limit[255:192] <= i_cfg_data;
                dr_pkg::CFG_NO_RETGT:   r_no_retgt       <= i_cfg_data[0];
                dr_pkg::CFG_TIMESPAN:   r_tt             <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Global advance: everything moves unless the output word is held.
    logic en;
    assign en = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ---- front end: clamp timespan, multiply by truncated mantissa
    logic signed [34:0] diff, lo, hi, span;
    logic [7:0]  size;
    logic [22:0] mant, m_eff;
    logic [7:0]  n_sh;

    always_comb begin
        diff = $signed({3'b000, i_last_block_time}) - $signed({3'b000, i_first_block_time});
        lo   = $signed({5'b00000, r_tt[31:2]});
        hi   = $signed({1'b0, r_tt, 2'b00});
        span = diff;
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        size = i_last_bits[31:24];
        mant = i_last_bits[22:0];
        // bytes that fall below bit 0 are dropped
        if (size >= 8'd3) begin
            m_eff = mant;
            n_sh  = size - 8'd3;
        end else begin
            n_sh = 8'd0;
            case (size)
                8'd2:    m_eff = {8'd0, mant[22:8]};
                8'd1:    m_eff = {16'd0, mant[22:16]};
                default: m_eff = 23'd0;
            endcase
        end
    end

    logic        r_f_valid;
    logic        r_f_pass;
    logic [31:0] r_f_bits;
    logic [56:0] r_f_prod;
    logic [7:0]  r_f_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= i_in_valid;
        end
        if (en) begin
            r_f_pass <= r_no_retgt;
            r_f_bits <= i_last_bits;
            r_f_prod <= m_eff * span[33:0];
            r_f_sh   <= n_sh;
        end
    end

    // byte shift, wraps modulo 2^256
    dr_pkg::t_cell_word row [0:dr_pkg::CELLS];
    logic [dr_pkg::TGT_W-1:0] scaled;
    assign scaled = {199'd0, r_f_prod} << {r_f_sh, 3'b000};
    assign row[0] = '{valid: r_f_valid, pass: r_f_pass, bits: r_f_bits,
                      rem: '0, word: scaled};

    // ---- divider row
    for (genvar g = 0; g < dr_pkg::CELLS; g++) begin : g_cell
        dr_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_t    (r_tt),
            .i_prev (row[g]),
            .o_next (row[g+1])
        );
    end

    // ---- pow-limit clamp; zero divisor gives zero
    dr_pkg::t_cell_word tail;
    logic [255:0] quot;
    assign tail = row[dr_pkg::CELLS];
    assign quot = (r_tt == 32'd0) ? '0 : tail.word;

    logic         r_c_valid;
    logic         r_c_pass;
    logic [31:0]  r_c_bits;
    logic [255:0] r_c_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= tail.valid;
        end
        if (en) begin
            r_c_pass <= tail.pass;
            r_c_bits <= tail.bits;
            r_c_val  <= (quot > r_limit) ? r_limit : quot;
        end
    end

    // ---- compact encode
    logic [7:0]   e_size;
    logic [255:0] e_tmp;
    logic [23:0]  e_c;
    logic [31:0]  n_out;

    always_comb begin
        e_size = 8'd0;
        for (int i = 0; i < 32; i++) begin
            if (r_c_val[8*i +: 8] != 8'd0) e_size = 8'(i + 1);
        end
        if (e_size >= 8'd3) e_tmp = r_c_val >> {e_size - 8'd3, 3'b000};
        else                e_tmp = r_c_val << {8'd3 - e_size, 3'b000};
        e_c = e_tmp[23:0];
        if (e_c[23]) begin
            e_c    = {8'd0, e_c[23:8]};
            e_size = e_size + 8'd1;
        end
        n_out = r_c_pass ? r_c_bits : {e_size, e_c};
    end

    logic r_o_pass;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (en) begin
            o_out_valid <= r_c_valid;
        end
        if (en) begin
            o_new_bits <= n_out;
            r_o_pass   <= r_c_pass;
        end
    end

    // ---- checks
    a_sign_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_o_pass |-> !o_new_bits[23])
        else $error("retargeted word has sign bit set");

    a_row_to_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail.valid && en |=> r_c_valid)
        else $error("word lost between divider row and clamp");

    a_hold_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(r_c_valid) && $stable(r_f_valid))
        else $error("pipeline moved while output held");

endmodule
`default_nettype wire

/* hw/rtl/dr_cell.sv */
// One divider cell: retires eight quotient bits of the 256-bit word.
// Depends on dr_pkg.
`default_nettype none
module dr_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_en,
    input  wire        [31:0] i_t,
    input  wire dr_pkg::t_cell_word i_prev,
    output dr_pkg::t_cell_word o_next
);

    dr_pkg::t_cell_word r_q;
    dr_pkg::t_cell_word n_q;

    always_comb begin
        logic [dr_pkg::REM_W:0] r;
        n_q = i_prev;
        for (int k = 0; k < dr_pkg::CELL_BITS; k++) begin
            r = {n_q.rem, n_q.word[dr_pkg::TGT_W-1]};
            n_q.word = {n_q.word[dr_pkg::TGT_W-2:0], 1'b0};
            if (r >= {1'b0, i_t}) begin
                r = r - {1'b0, i_t};
                n_q.word[0] = 1'b1;
            end
            n_q.rem = r[dr_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_next = r_q;

endmodule
`default_nettype wire

/* tb/difficulty_retarget_test.sv */
// Testbench for difficulty_retarget: random and directed compact targets and block times,
// checked against a predictor of the retarget rule under several register settings.
// Depends on dr_pkg and the difficulty_retarget RTL.
`timescale 1ns / 100ps
`default_nettype none

// Predicts each new compact target and holds the ones still owed by the block.
class retarget_scoreboard;
    logic [255:0] pow_limit;
    bit           no_retgt;
    logic [31:0]  tspan;
    logic [31:0]  owed_bits[$];
    int           errors;

    function new();
        pow_limit = {64'h0000_0000_FFFF_FFFF, {192{1'b1}}};
        no_retgt  = 1'b0;
        tspan     = 32'd1209600;
        errors    = 0;
    endfunction

    // byte of a 256-bit target, zero outside the 32 byte slots
    function logic [7:0] get_byte(logic [255:0] v, int pos);
        if (pos < 0 || pos > 31) return 8'h00;
        return v[pos*8 +: 8];
    endfunction

    function logic [255:0] decode(logic [31:0] bits);
        logic [255:0] v;
        int size;
        v = '0;
        size = int'(bits[31:24]);
        // sign bit dropped; bytes that fall outside the 256 bits vanish
        if (size - 1 >= 0 && size - 1 <= 31) v[(size-1)*8 +: 8] = {1'b0, bits[22:16]};
        if (size - 2 >= 0 && size - 2 <= 31) v[(size-2)*8 +: 8] = bits[15:8];
        if (size - 3 >= 0 && size - 3 <= 31) v[(size-3)*8 +: 8] = bits[7:0];
        return v;
    endfunction

    function logic [31:0] encode(logic [255:0] v);
        int size;
        int i;
        logic [31:0] c;
        size = 0;
        for (i = 31; i >= 0; i--) begin
            if (v[i*8 +: 8] != 8'h00) begin
                size = i + 1;
                break;
            end
        end
        c = {8'h00, get_byte(v, size - 1), get_byte(v, size - 2), get_byte(v, size - 3)};
        // keep the sign bit clear by moving to the next exponent
        if (c[23]) begin
            c = c >> 8;
            size++;
        end
        return c | (32'(size) << 24);
    endfunction

    // accepted input word: work out the new compact target
    function void note_word(logic [31:0] bits, logic [31:0] last_t, logic [31:0] first_t);
        longint span;
        longint lo;
        longint hi;
        logic [255:0] v;
        if (no_retgt) begin
            owed_bits.push_back(bits);
            return;
        end
        span = longint'({32'h0, last_t}) - longint'({32'h0, first_t});
        lo = longint'({32'h0, tspan}) / 4;
        hi = longint'({32'h0, tspan}) * 4;
        if (span < lo) span = lo;
        if (span > hi) span = hi;
        v = decode(bits);
        v = v * 256'(span);
        if (tspan != 0) v = v / 256'(tspan);
        else v = '0;
        if (v > pow_limit) v = pow_limit;
        owed_bits.push_back(encode(v));
    endfunction

    function void check_word(logic [31:0] actual);
        logic [31:0] exp_bits;
        if (owed_bits.size() == 0) begin
            $error("new_bits: no word expected, actual %h", actual);
            errors++;
            return;
        end
        exp_bits = owed_bits.pop_front();
        if (actual !== exp_bits) begin
            $error("new_bits: expected %h, actual %h", exp_bits, actual);
            errors++;
        end
    endfunction
endclass

module difficulty_retarget_test;

    localparam int DRAIN_CYCLES = 45;   // pipeline is 35 deep

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [31:0] i_last_bits = '0;
    logic [31:0] i_last_block_time = '0;
    logic [31:0] i_first_block_time = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_new_bits;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    retarget_scoreboard sb = new();

    int  send_idle_pct = 17;
    int  recv_idle_pct = 87;
    int  words_checked = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    difficulty_retarget dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_last_bits        (i_last_bits),
        .i_last_block_time  (i_last_block_time),
        .i_first_block_time (i_first_block_time),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_new_bits         (o_new_bits),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Receiver: samples the pre-edge output, then picks the next stall.
    // Once, after a hundred words, it holds off long enough to back up the
    // whole pipeline so the input side has to stall.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            sb.check_word(o_new_bits);
            words_checked++;
        end
        if (!hold_done && words_checked >= 100) begin
            hold_done <= 1'b1;
            hold_left <= 300;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offer one input word, with random idle cycles first; valid stays up on return.
    task automatic send_word(logic [31:0] bits, logic [31:0] last_t, logic [31:0] first_t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_last_bits        <= bits;
        i_last_block_time  <= last_t;
        i_first_block_time <= first_t;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(bits, last_t, first_t);
    endtask

    // Drain the pipeline, then write every register.
    task automatic set_config(logic [255:0] limit, bit no_retgt, logic [31:0] tspan);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed_bits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        for (int r = 0; r < 6; r++) begin
            i_cfg_we <= 1'b1;
            case (r)
                0: begin
                    i_cfg_index <= dr_pkg::CFG_POW_LIMIT0;
                    i_cfg_data  <= limit[63:0];
                end
                1: begin
                    i_cfg_index <= dr_pkg::CFG_POW_LIMIT1;
                    i_cfg_data  <= limit[127:64];
                end
                2: begin
                    i_cfg_index <= dr_pkg::CFG_POW_LIMIT2;
                    i_cfg_data  <= limit[191:128];
                end
                3: begin
                    i_cfg_index <= dr_pkg::CFG_POW_LIMIT3;
                    i_cfg_data  <= limit[255:192];
                end
                4: begin
                    i_cfg_index <= dr_pkg::CFG_NO_RETGT;
                    i_cfg_data  <= 64'(no_retgt);
                end
                default: begin
                    i_cfg_index <= dr_pkg::CFG_TIMESPAN;
                    i_cfg_data  <= 64'(tspan);
                end
            endcase
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        sb.pow_limit = limit;
        sb.no_retgt  = no_retgt;
        sb.tspan     = tspan;
    endtask

    function automatic logic [31:0] rand_bits();
        logic [31:0] b;
        b = $urandom();
        // mostly exponents around the interesting range, sometimes anything
        if ($urandom_range(3) != 0) b[31:24] = 8'($urandom_range(36));
        return b;
    endfunction

    // Random burst; most spans land near the clamp window of the current T.
    task automatic random_words(int count);
        logic [31:0] first_t;
        logic [31:0] last_t;
        logic [63:0] t4;
        for (int n = 0; n < count; n++) begin
            first_t = $urandom();
            t4 = 64'(sb.tspan) * 4;
            case ($urandom_range(3))
                0: last_t = $urandom();
                1: last_t = first_t + 32'($urandom_range(32'(t4 > 64'hFFFF_FFFF ?
                                                          64'hFFFF_FFFF : t4)));
                2: last_t = first_t + sb.tspan / 4 - 32'($urandom_range(3));
                default: last_t = first_t + sb.tspan + 32'($urandom_range(1000));
            endcase
            send_word(rand_bits(), last_t, first_t);
        end
    endtask

    initial begin
        logic [255:0] lim;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words under reset settings
        send_word(32'h1d00ffff, 32'd1209600, 32'd0);          // nominal
        send_word(32'h1d00ffff, 32'd0, 32'd1209600);          // negative span, low clamp
        send_word(32'h1d00ffff, 32'hFFFF_FFFF, 32'd0);        // high clamp
        send_word(32'h00000000, 32'd5, 32'd0);                // zero target
        send_word(32'hFFFF_FFFF, 32'd1209600, 32'd0);         // sign set, oversize exponent
        send_word(32'h01FF_FFFF, 32'd1209600, 32'd0);         // tiny exponents drop bytes
        send_word(32'h0212_3456, 32'd1209600, 32'd0);
        send_word(32'h0312_3456, 32'd1209600, 32'd0);
        send_word(32'h2000_0001, 32'd2419200, 32'd0);         // top byte region
        send_word(32'h2112_3456, 32'd1209600, 32'd0);         // partly above bit 255
        send_word(32'h2312_3456, 32'd1209600, 32'd0);         // entirely above
        send_word(32'h1d80_0000, 32'd1209600, 32'd0);         // sign only
        send_word(32'h207F_FFFF, 32'd4838400, 32'd0);         // product wraps, limit clamp
        send_word(32'h0300_0080, 32'd1209600, 32'd0);         // renormalize on encode
        send_word(32'h1b04_864c, 32'd1000, 32'd1000);         // zero span
        send_word(32'h1b04_864c, 32'd0, 32'hFFFF_FFFF);
        random_words(200);

        // minimum T, zero limit
        set_config('0, 1'b0, 32'd4);
        send_word(32'h2000_0001, 32'd3, 32'd0);
        random_words(150);

        // maximum T, full limit; receiver now idles less, sender more
        send_idle_pct = 87;
        recv_idle_pct = 17;
        set_config({256{1'b1}}, 1'b0, 32'hFFFF_FFFF);
        send_word(32'h2212_3456, 32'hFFFF_FFFF, 32'd0);
        random_words(200);

        // pass-through
        set_config({256{1'b1}}, 1'b1, 32'd1209600);
        random_words(150);

        // small random limit and random T
        lim = {192'h0, 32'h0, 32'($urandom())};
        set_config(lim, 1'b0, 32'($urandom_range(32'hFFFF_FFFF, 4)));
        random_words(200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        lim = {32'h0, 32'($urandom()), 32'($urandom()), 32'($urandom()),
               32'($urandom()), 32'($urandom()), 32'($urandom()), 32'($urandom())};
        set_config(lim, 1'b0, 32'($urandom_range(5000, 4)));
        random_words(200);

        set_config({64'h0, 64'hFFFF_FFFF, {128{1'b1}}}, 1'b0, 32'd1209600);
        random_words(200);

        i_in_valid <= 1'b0;
        while (sb.owed_bits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/dr_pkg.sv
hw/rtl/dr_cell.sv
hw/rtl/difficulty_retarget.sv
tb/difficulty_retarget_test.sv
